[sv/lse_pkg.sv]
// ----------------------------------------------------------------------------
// lse_pkg: shared types and constants for the LSB embed/extract block
// Item and result layouts, register indexes, mode codes and header sizes.
// ----------------------------------------------------------------------------
package lse_pkg;

  localparam int unsigned HdrBytes = 4;
  localparam int unsigned IdxW     = 33;
  localparam int unsigned LenW     = 32;

  localparam logic [7:0] LsbClear = 8'hfe;
  localparam logic [7:0] LsbMask  = 8'h01;

  // Operating modes.
  localparam logic MODE_EMBED   = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_MODE   = 1'b0;
  localparam logic CFG_LENGTH = 1'b1;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] sample;
    logic [7:0] payload_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]      sample_out;
    logic            need_byte;
    logic            byte_valid;
    logic [7:0]      byte_out;
    logic [LenW-1:0] found_length;
    logic            last;
  } result_t;

endpackage

[sv/lse_step.sv]
// ----------------------------------------------------------------------------
// lse_step: message state and per-sample embed/extract logic
// Holds the bit and byte counters, the shift byte and the recovered length,
// and computes the result for one sample from the current state.
// ----------------------------------------------------------------------------
module lse_step (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   mode_i,
  input  logic [31:0]            payload_length_i,
  input  lse_pkg::item_t         item_i,
  output lse_pkg::result_t       result_o
);
  import lse_pkg::*;

  logic [2:0]      bit_pos_q, bit_pos_d;
  logic [IdxW-1:0] byte_idx_q, byte_idx_d;
  logic [7:0]      shift_q, shift_d;
  logic [LenW-1:0] hdr_len_q, hdr_len_d;
  logic            done_q, done_d;

  // State as seen by this sample, after an optional frame restart.
  logic [2:0]      bp;
  logic [IdxW-1:0] idx;
  logic [7:0]      sh;
  logic [LenW-1:0] hl;
  logic            dn;

  logic [IdxW-1:0] emb_total;
  logic [IdxW-1:0] ext_total;
  logic [IdxW-1:0] idx_inc;
  logic [2:0]      bp_inc;
  logic [7:0]      hdr_byte;
  logic [7:0]      emb_byte;
  logic [7:0]      ext_byte;
  logic [LenW-1:0] hl_shift;
  logic            in_hdr;
  logic            emb_bit;

  always_comb begin
    bp  = item_i.frame_start ? '0 : bit_pos_q;
    idx = item_i.frame_start ? '0 : byte_idx_q;
    sh  = item_i.frame_start ? '0 : shift_q;
    hl  = item_i.frame_start ? '0 : hdr_len_q;
    dn  = item_i.frame_start ? 1'b0 : done_q;
  end

  assign emb_total = IdxW'(HdrBytes) + {1'b0, payload_length_i};
  assign idx_inc   = idx + IdxW'(1);
  assign bp_inc    = bp + 3'd1;
  assign in_hdr    = (idx < IdxW'(HdrBytes));
  assign hl_shift  = {hl[LenW-9:0], ext_byte};
  assign ext_byte  = {sh[6:0], item_i.sample[0]};

  always_comb begin
    case (idx[1:0])
      2'd0:    hdr_byte = payload_length_i[31:24];
      2'd1:    hdr_byte = payload_length_i[23:16];
      2'd2:    hdr_byte = payload_length_i[15:8];
      default: hdr_byte = payload_length_i[7:0];
    endcase
  end

  // A new byte is loaded only at the start of a byte; otherwise the held byte is kept.
  always_comb begin
    if (bp == 3'd0) begin
      emb_byte = in_hdr ? hdr_byte : item_i.payload_byte;
    end else begin
      emb_byte = sh;
    end
  end

  assign emb_bit = emb_byte[3'd7 - bp];

  // Total message bytes from the header length held as this sample is seen.
  assign ext_total = IdxW'(HdrBytes) + {1'b0, hl};

  always_comb begin
    bit_pos_d  = bp;
    byte_idx_d = idx;
    shift_d    = sh;
    hdr_len_d  = hl;
    done_d     = dn;
    result_o   = '0;
    result_o.sample_out = item_i.sample;

    if (mode_i == MODE_EMBED) begin
      if (!dn && (idx < emb_total)) begin
        shift_d = emb_byte;
        result_o.need_byte  = (bp == 3'd0) && !in_hdr;
        result_o.sample_out = (item_i.sample & LsbClear) | {7'b0, emb_bit};
        bit_pos_d = bp_inc;
        if (bp_inc == 3'd0) begin
          byte_idx_d = idx_inc;
          if (idx_inc == emb_total) begin
            done_d        = 1'b1;
            result_o.last = 1'b1;
          end
        end
      end else begin
        done_d = 1'b1;
      end
    end else begin
      if (!dn) begin
        shift_d   = ext_byte;
        bit_pos_d = bp_inc;
        if (bp_inc == 3'd0) begin
          shift_d    = '0;
          byte_idx_d = idx_inc;
          if (in_hdr) begin
            hdr_len_d = hl_shift;
            if ((idx_inc == IdxW'(HdrBytes)) && (hl_shift == '0)) begin
              done_d        = 1'b1;
              result_o.last = 1'b1;
            end
          end else begin
            result_o.byte_valid = 1'b1;
            result_o.byte_out   = ext_byte;
            if (idx_inc >= ext_total) begin
              done_d        = 1'b1;
              result_o.last = 1'b1;
            end
          end
        end
      end
      if (byte_idx_d >= IdxW'(HdrBytes)) begin
        result_o.found_length = hdr_len_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_pos_q  <= '0;
      byte_idx_q <= '0;
      shift_q    <= '0;
      hdr_len_q  <= '0;
      done_q     <= 1'b0;
    end else if (en_i) begin
      bit_pos_q  <= bit_pos_d;
      byte_idx_q <= byte_idx_d;
      shift_q    <= shift_d;
      hdr_len_q  <= hdr_len_d;
      done_q     <= done_d;
    end
  end

endmodule

[sv/lsb_stego_embed_extract.sv]
// ----------------------------------------------------------------------------
// lsb_stego_embed_extract: LSB message embed and extract with length header
// Hides a length-prefixed message in sample LSBs, or recovers it, one sample
// per transaction.
// ----------------------------------------------------------------------------
// Path: an accepted sample waits in the input register until the result
// register is free, then its result is registered there for the outputs.
// Throughput: one sample per cycle unless the output stalls; the state
// update is a single step from the input register to the result register.
// Reset: counters, message state and both valid flags clear; mode resets to
// embed and payload_length to zero.
module lsb_stego_embed_extract (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        frame_start_i,
  input  logic [7:0]  sample_i,
  input  logic [7:0]  payload_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  sample_out_o,
  output logic        need_byte_o,
  output logic        byte_valid_o,
  output logic [7:0]  byte_out_o,
  output logic [31:0] found_length_o,
  output logic        last_o
);
  import lse_pkg::*;

  logic            mode_q;
  logic [LenW-1:0] length_q;

  item_t   item_q;
  logic    item_valid_q;
  result_t res_d, res_q;
  logic    res_valid_q;
  logic    advance;
  logic    res_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_EMBED;
      length_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:   mode_q   <= cfg_data_i[0];
        CFG_LENGTH: length_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  assign res_free   = !res_valid_q || out_ready_i;
  assign advance    = item_valid_q && res_free;
  assign in_ready_o = !item_valid_q || res_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q.frame_start  <= frame_start_i;
      item_q.sample       <= sample_i;
      item_q.payload_byte <= payload_byte_i;
    end
  end

  lse_step u_step (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (advance),
    .mode_i           (mode_q),
    .payload_length_i (length_q),
    .item_i           (item_q),
    .result_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_free) begin
      res_valid_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = res_valid_q;
  assign sample_out_o   = res_q.sample_out;
  assign need_byte_o    = res_q.need_byte;
  assign byte_valid_o   = res_q.byte_valid;
  assign byte_out_o     = res_q.byte_out;
  assign found_length_o = res_q.found_length;
  assign last_o         = res_q.last;

  // A payload byte is consumed only when embedding and recovered only when
  // extracting, so the two flags never meet.
  a_need_xor_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(need_byte_o && byte_valid_o))
    else $error("need_byte and byte_valid both set");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !byte_valid_o) |-> (byte_out_o == 8'h00))
    else $error("byte_out nonzero without byte_valid");

  a_embed_no_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (mode_q == MODE_EMBED)) |-> (found_length_o == '0 && !byte_valid_o))
    else $error("extract outputs active in embed mode");

  a_result_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_q && res_free) |=> out_valid_o)
    else $error("advanced sample did not reach the result register");

endmodule
